// ===== rtl/dynamic_mex_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dynamic mex tracker
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_MEX_TRACKER_UNIT_ASSERT_SVH
`define DYNAMIC_MEX_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define DMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared types and constants of the dynamic mex tracker.
// ----------------------------------------------------------------------------
package dmt_pkg;

  // default sizes
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned LEAF_COUNT_DEF   = 2048;

  // word field widths
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MEX_W    = 11;
  localparam int unsigned ECOUNT_W = 11;

  localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = 11'd1024;

  // command codes
  localparam logic [CMD_W-1:0] CMD_QUERY   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [MEX_W-1:0] mex;
    logic             index_error;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELEM,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_UP,
    ST_DESC_START,
    ST_DESC,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_INC,
    ALU_DEC,
    ALU_MIN
  } alu_op_t;

endpackage

// ===== rtl/dmt_alu.sv =====
// ----------------------------------------------------------------------------
// dmt_alu
// Shared count unit: increment, saturating decrement, minimum, and a
// less-or-equal flag used by the tree descent.
// ----------------------------------------------------------------------------
module dmt_alu #(
  parameter int unsigned W = 11
) (
  input  dmt_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             le
);
  import dmt_pkg::*;

  // left wins ties
  assign le = (a <= b);

  always_comb begin
    unique case (op)
      ALU_INC: res = a + W'(1);
      ALU_DEC: res = (a != '0) ? a - W'(1) : a;
      ALU_MIN: res = le ? a : b;
      default: res = a;
    endcase
  end

endmodule

// ===== rtl/dmt_tree_ram.sv =====
// ----------------------------------------------------------------------------
// dmt_tree_ram
// Min-tree node storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dmt_tree_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/dynamic_mex_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// dynamic_mex_tracker_unit
// Element store plus a min-tree of value counts; every word reports the
// smallest value with a zero count, after an optional element replace.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_we                | cfg_wdata (element_count)
//  in      | in        | in_valid / in_ready   | in_data  (command, index, value)
//  out     | out       | out_valid / out_ready | out_data (mex, index_error)
//
//  Query: the tree descent, one level per cycle, sets the time taken. Replace:
//  one element store read, up to two leaf-to-root updates and the descent,
//  all on the single tree write port and the shared count unit.
//  After reset a clearing pass zeroes the tree and the element store;
//  in_ready stays low until it ends.
//  The output register lets the next word be taken while a result waits.
// ----------------------------------------------------------------------------
module dynamic_mex_tracker_unit #(
  parameter int unsigned MAX_ELEMENTS = dmt_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned LEAF_COUNT   = dmt_pkg::LEAF_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dmt_pkg::ECOUNT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dmt_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dmt_pkg::out_word_t            out_data
);
  import dmt_pkg::*;

  localparam int unsigned LV_W  = $clog2(LEAF_COUNT);
  localparam int unsigned TA_W  = LV_W + 1;
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned EA_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  localparam logic [TA_W-1:0] ROOT      = TA_W'(1);
  localparam logic [TA_W-1:0] CLR_LAST  = {TA_W{1'b1}};
  localparam logic [TA_W-1:0] MAX_EL_TA = TA_W'(MAX_ELEMENTS);

  // control registers
  state_t               state;
  state_t               state_next;
  logic [TA_W-1:0]      clr;
  logic [ECOUNT_W-1:0]  element_count;

  // item registers
  logic [TA_W-1:0]      node;
  logic [CNT_W-1:0]     cur;
  logic                 dec_phase;
  logic [EA_W-1:0]      idx_q;
  logic                 new_cnt;
  logic [LV_W-1:0]      new_leaf;
  logic                 err_q;
  logic [LV_W-1:0]      mex_q;

  // element store: MSB is the counted flag
  logic [LV_W:0]        elem_mem [MAX_ELEMENTS];
  logic [LV_W:0]        elem_rdata;
  logic [EA_W-1:0]      elem_raddr;
  logic                 elem_we;
  logic [EA_W-1:0]      elem_waddr;
  logic [LV_W:0]        elem_wdata;

  // tree port and shared unit
  logic                 tree_we;
  logic [TA_W-1:0]      tree_waddr;
  logic [CNT_W-1:0]     tree_wdata;
  logic [TA_W-1:0]      tree_raddr_a;
  logic [TA_W-1:0]      tree_raddr_b;
  logic [CNT_W-1:0]     tree_rdata_a;
  logic [CNT_W-1:0]     tree_rdata_b;
  alu_op_t              alu_op;
  logic [CNT_W-1:0]     alu_a;
  logic [CNT_W-1:0]     alu_b;
  logic [CNT_W-1:0]     alu_res;
  logic                 alu_le;

  // decoded helpers
  logic                 idx_ok;
  logic                 val_ok;
  logic                 old_counted;
  logic [LV_W-1:0]      old_leaf;
  logic [TA_W-1:0]      sib;
  logic [TA_W-1:0]      parent;
  logic [TA_W-1:0]      child;
  logic                 child_leaf;
  logic                 path_done;
  logic                 out_free;
  logic                 out_load;

  assign idx_ok = (ECOUNT_W'(in_data.index) < element_count) &&
                  (32'(in_data.index) < 32'(MAX_ELEMENTS));
  assign val_ok = (in_data.value <= VALUE_W'(element_count)) &&
                  (in_data.value < VALUE_W'(LEAF_COUNT));

  assign old_counted = elem_rdata[LV_W];
  assign old_leaf    = elem_rdata[LV_W-1:0];
  assign sib         = node ^ TA_W'(1);
  assign parent      = node >> 1;
  assign child       = {node[TA_W-2:0], ~alu_le};
  assign child_leaf  = child[TA_W-1];
  assign path_done   = (node == ROOT);
  assign out_free    = !out_valid || out_ready;
  assign elem_raddr  = EA_W'(in_data.index);

  // shared count unit
  dmt_alu #(
    .W (CNT_W)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .le  (alu_le)
  );

  // min-tree storage
  dmt_tree_ram #(
    .ADDR_W (TA_W),
    .DATA_W (CNT_W)
  ) u_tree (
    .clk     (clk),
    .we      (tree_we),
    .waddr   (tree_waddr),
    .wdata   (tree_wdata),
    .raddr_a (tree_raddr_a),
    .raddr_b (tree_raddr_b),
    .rdata_a (tree_rdata_a),
    .rdata_b (tree_rdata_b)
  );

  // element store
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    elem_rdata <= elem_mem[elem_raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_data.command == CMD_REPLACE) && idx_ok) state_next = ST_ELEM;
          else state_next = ST_DESC_START;
        end
      end
      ST_ELEM: begin
        if (old_counted || new_cnt) state_next = ST_LEAF_RD;
        else state_next = ST_DESC_START;
      end
      ST_LEAF_RD: state_next = ST_LEAF_WR;
      ST_LEAF_WR: state_next = ST_UP;
      ST_UP: begin
        if (path_done) begin
          if (dec_phase && new_cnt) state_next = ST_LEAF_RD;
          else state_next = ST_DESC_START;
        end
      end
      ST_DESC_START: state_next = ST_DESC;
      ST_DESC: begin
        if (child_leaf) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // shared count unit operands
  always_comb begin
    alu_op = ALU_MIN;
    alu_a  = cur;
    alu_b  = tree_rdata_a;
    unique case (state)
      ST_LEAF_WR: begin
        alu_op = dec_phase ? ALU_DEC : ALU_INC;
        alu_a  = tree_rdata_a;
      end
      ST_DESC: begin
        alu_a = tree_rdata_a;
        alu_b = tree_rdata_b;
      end
      default: begin
        alu_op = ALU_MIN;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    tree_we      = 1'b0;
    tree_waddr   = node;
    tree_wdata   = alu_res;
    tree_raddr_a = sib;
    tree_raddr_b = sib;
    elem_we      = 1'b0;
    elem_waddr   = idx_q;
    elem_wdata   = {new_cnt, (new_cnt ? new_leaf : {LV_W{1'b0}})};
    unique case (state)
      ST_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr;
        tree_wdata = '0;
        elem_we    = (clr < MAX_EL_TA);
        elem_waddr = clr[EA_W-1:0];
        elem_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ELEM: begin
        elem_we = 1'b1;
      end
      ST_LEAF_RD: begin
        tree_raddr_a = node;
      end
      ST_LEAF_WR: begin
        tree_we = 1'b1;
      end
      ST_UP: begin
        tree_we = 1'b1;
      end
      ST_DESC_START: begin
        tree_raddr_a = {ROOT[TA_W-2:0], 1'b0};
        tree_raddr_b = {ROOT[TA_W-2:0], 1'b1};
      end
      ST_DESC: begin
        tree_raddr_a = {child[TA_W-2:0], 1'b0};
        tree_raddr_b = {child[TA_W-2:0], 1'b1};
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control state: clearing sweep, register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr           <= '0;
      element_count <= ECOUNT_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) element_count <= cfg_wdata;
      if (state == ST_CLEAR) clr <= clr + TA_W'(1);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{mex: MEX_W'(mex_q), index_error: err_q};
    end
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          idx_q    <= EA_W'(in_data.index);
          new_cnt  <= val_ok;
          new_leaf <= LV_W'(in_data.value);
          err_q    <= (in_data.command == CMD_REPLACE) && !idx_ok;
        end
      end
      ST_ELEM: begin
        // uncount the old value first, then count the new one
        if (old_counted) begin
          node      <= {1'b1, old_leaf};
          dec_phase <= 1'b1;
        end else begin
          node      <= {1'b1, new_leaf};
          dec_phase <= 1'b0;
        end
      end
      ST_LEAF_WR: begin
        cur  <= alu_res;
        node <= parent;
      end
      ST_UP: begin
        cur <= alu_res;
        if (path_done) begin
          node      <= {1'b1, new_leaf};
          dec_phase <= 1'b0;
        end else begin
          node <= parent;
        end
      end
      ST_DESC_START: begin
        node <= ROOT;
      end
      ST_DESC: begin
        node <= child;
        if (child_leaf) mex_q <= child[LV_W-1:0];
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // checks
  `include "dynamic_mex_tracker_unit_assert.svh"

  `DMT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `DMT_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE, "result not from done")
  `DMT_ASSERT_IMP(a_up_not_leaf, state == ST_UP, !node[TA_W-1], "leaf node in upward walk")
  `DMT_ASSERT_IMP(a_replace_no_err, state == ST_ELEM, !err_q, "flagged replace was applied")

endmodule
